### hw/rtl/rpy_pkg.sv
`timescale 1ns / 1ps

package rpy_pkg;

    localparam int CORDIC_ITERATIONS = 16;
    localparam int FRACTION_BITS     = 14;

    localparam int ANGLE_W = 16;
    localparam int OUT_W   = 16;
    localparam int OUT_FRAC = 14;
    localparam int OUT_ONE  = 16384;

    // angle accumulator in units of 2^-29 rad
    localparam int Z_W   = 32;
    localparam int IDX_W = (CORDIC_ITERATIONS > 1) ? $clog2(CORDIC_ITERATIONS) : 1;
    localparam int XY_W  = FRACTION_BITS + 4;
    localparam int SC_W  = FRACTION_BITS + 2;

    localparam longint ANG_PI      = 64'sd1686629713;
    localparam longint ANG_HALF_PI = 64'sd843314857;
    localparam longint GAIN_Q30    = 64'sd652032874;
    localparam longint X_INIT =
        ((GAIN_Q30 <<< FRACTION_BITS) + (64'sd1 <<< 29)) >>> 30;
    localparam longint SC_ONE = 64'sd1 <<< FRACTION_BITS;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic                   neg;
    } cordic_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] r00;
        logic signed [OUT_W-1:0] r01;
        logic signed [OUT_W-1:0] r02;
        logic signed [OUT_W-1:0] r10;
        logic signed [OUT_W-1:0] r11;
        logic signed [OUT_W-1:0] r12;
        logic signed [OUT_W-1:0] r20;
        logic signed [OUT_W-1:0] r21;
        logic signed [OUT_W-1:0] r22;
    } matrix_t;

    function automatic logic signed [Z_W-1:0] atan_entry(input logic [IDX_W-1:0] i);
        logic signed [Z_W-1:0] v;
        v = '0;
        unique case (int'(i))
            0: v = 32'sd421657428;
            1: v = 32'sd248918915;
            2: v = 32'sd131521918;
            3: v = 32'sd66762579;
            4: v = 32'sd33510843;
            5: v = 32'sd16771758;
            6: v = 32'sd8387925;
            7: v = 32'sd4194219;
            8: v = 32'sd2097141;
            9: v = 32'sd1048575;
            default: v = (int'(i) > 29) ? '0 : (Z_W'(1) <<< (29 - int'(i)));
        endcase
        return v;
    endfunction

endpackage

### hw/rtl/rpy_angle_if.sv
`timescale 1ns / 1ps

interface rpy_angle_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] roll_angle;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] yaw_angle;

    modport source (output valid, roll_angle, pitch_angle, yaw_angle, input ready);
    modport sink   (input valid, roll_angle, pitch_angle, yaw_angle, output ready);
endinterface

### hw/rtl/rpy_matrix_if.sv
`timescale 1ns / 1ps

interface rpy_matrix_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] r00;
    logic signed [15:0] r01;
    logic signed [15:0] r02;
    logic signed [15:0] r10;
    logic signed [15:0] r11;
    logic signed [15:0] r12;
    logic signed [15:0] r20;
    logic signed [15:0] r21;
    logic signed [15:0] r22;

    modport source (output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22, input ready);
    modport sink   (input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22, output ready);
endinterface

### hw/rtl/rpy_cordic_stage.sv
`timescale 1ns / 1ps

module rpy_cordic_stage
    import rpy_pkg::*;
(
    input  logic             clk,
    input  logic             en,
    input  logic [IDX_W-1:0] shift,
    input  cordic_t          d,
    output cordic_t          q
);

    cordic_t q_reg;
    cordic_t q_next;
    logic signed [XY_W-1:0] dx;
    logic signed [XY_W-1:0] dy;
    logic signed [Z_W-1:0]  da;

    always_comb
    begin
        dx = d.y >>> shift;
        dy = d.x >>> shift;
        da = atan_entry(shift);
        q_next = d;
        if (!d.z[Z_W-1])
        begin
            q_next.x = d.x - dx;
            q_next.y = d.y + dy;
            q_next.z = d.z - da;
        end
        else
        begin
            q_next.x = d.x + dx;
            q_next.y = d.y - dy;
            q_next.z = d.z + da;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

### hw/rtl/rpy_sincos.sv
`timescale 1ns / 1ps

module rpy_sincos
    import rpy_pkg::*;
(
    input  logic                      clk,
    input  logic                      en,
    input  logic signed [ANGLE_W-1:0] angle,
    output logic signed [SC_W-1:0]    sin_val,
    output logic signed [SC_W-1:0]    cos_val
);

    localparam int ZE_W = Z_W + 1;

    cordic_t chain [CORDIC_ITERATIONS+1];
    cordic_t fold_reg;
    cordic_t fold_next;
    logic signed [SC_W-1:0] sin_reg, sin_next;
    logic signed [SC_W-1:0] cos_reg, cos_next;
    logic signed [ZE_W-1:0] z_ext;
    logic signed [XY_W-1:0] xf, yf;

    // fold into +-pi/2, remember to negate
    always_comb
    begin
        z_ext = ZE_W'(angle) <<< 16;
        fold_next.x = XY_W'(X_INIT);
        fold_next.y = '0;
        fold_next.neg = 1'b0;
        fold_next.z = Z_W'(z_ext);
        if (z_ext > ZE_W'(ANG_HALF_PI))
        begin
            fold_next.z = Z_W'(z_ext - ZE_W'(ANG_PI));
            fold_next.neg = 1'b1;
        end
        else if (z_ext < -ZE_W'(ANG_HALF_PI))
        begin
            fold_next.z = Z_W'(z_ext + ZE_W'(ANG_PI));
            fold_next.neg = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fold_reg <= fold_next;
            sin_reg  <= sin_next;
            cos_reg  <= cos_next;
        end
    end

    assign chain[0] = fold_reg;

    for (genvar i = 0; i < CORDIC_ITERATIONS; i++)
    begin : g_stage
        rpy_cordic_stage u_stage (
            .clk   (clk),
            .en    (en),
            .shift (IDX_W'(i)),
            .d     (chain[i]),
            .q     (chain[i+1])
        );
    end

    // undo fold and clamp to +-1
    always_comb
    begin
        xf = chain[CORDIC_ITERATIONS].neg ? -chain[CORDIC_ITERATIONS].x
                                          :  chain[CORDIC_ITERATIONS].x;
        yf = chain[CORDIC_ITERATIONS].neg ? -chain[CORDIC_ITERATIONS].y
                                          :  chain[CORDIC_ITERATIONS].y;
        if (xf > XY_W'(SC_ONE))
            cos_next = SC_W'(SC_ONE);
        else if (xf < -XY_W'(SC_ONE))
            cos_next = -SC_W'(SC_ONE);
        else
            cos_next = SC_W'(xf);
        if (yf > XY_W'(SC_ONE))
            sin_next = SC_W'(SC_ONE);
        else if (yf < -XY_W'(SC_ONE))
            sin_next = -SC_W'(SC_ONE);
        else
            sin_next = SC_W'(yf);
    end

    assign sin_val = sin_reg;
    assign cos_val = cos_reg;

endmodule

### hw/rtl/rpy_matrix.sv
`timescale 1ns / 1ps

module rpy_matrix
    import rpy_pkg::*;
(
    input  logic                   clk,
    input  logic                   en,
    input  logic signed [SC_W-1:0] sg,
    input  logic signed [SC_W-1:0] cg,
    input  logic signed [SC_W-1:0] sb,
    input  logic signed [SC_W-1:0] cb,
    input  logic signed [SC_W-1:0] sa,
    input  logic signed [SC_W-1:0] ca,
    output matrix_t                mat
);

    localparam int P_W  = 2 * SC_W;
    localparam int T_W  = SC_W + 1;
    localparam int Q_W  = SC_W + T_W;
    localparam int A_W  = Q_W + 2;
    localparam int SH   = 2 * FRACTION_BITS - OUT_FRAC;

    typedef struct packed {
        logic signed [P_W-1:0] ca_sb, sa_sb, ca_cb, sa_cb, sa_cg, sa_sg;
        logic signed [P_W-1:0] ca_cg, ca_sg, cb_sg, cb_cg;
        logic signed [SC_W-1:0] sg, cg, sb;
    } m1_t;

    typedef struct packed {
        logic signed [T_W-1:0] t1, t2;
        logic signed [P_W-1:0] ca_cb, sa_cb, sa_cg, sa_sg, ca_cg, ca_sg, cb_sg, cb_cg;
        logic signed [SC_W-1:0] sg, cg, sb;
    } m2_t;

    typedef struct packed {
        logic signed [Q_W-1:0] t1_sg, t1_cg, t2_sg, t2_cg;
        logic signed [P_W-1:0] ca_cb, sa_cb, sa_cg, sa_sg, ca_cg, ca_sg, cb_sg, cb_cg;
        logic signed [SC_W-1:0] sb;
    } m3_t;

    typedef struct packed {
        logic signed [A_W-1:0] a00, a01, a02, a10, a11, a12, a20, a21, a22;
    } m4_t;

    m1_t m1_reg, m1_next;
    m2_t m2_reg, m2_next;
    m3_t m3_reg, m3_next;
    m4_t m4_reg, m4_next;
    matrix_t mat_reg, mat_next;

    function automatic logic signed [T_W-1:0] round_fb(input logic signed [P_W-1:0] p);
        logic signed [P_W:0] s;
        s = ((P_W+1)'(p) + ((P_W+1)'(1) <<< (FRACTION_BITS - 1))) >>> FRACTION_BITS;
        return T_W'(s);
    endfunction

    function automatic logic signed [OUT_W-1:0] to_out(input logic signed [A_W-1:0] a);
        logic signed [A_W:0] v;
        v = ((A_W+1)'(a) + ((A_W+1)'(1) <<< (SH - 1))) >>> SH;
        if (v > (A_W+1)'(OUT_ONE))
            return OUT_W'(OUT_ONE);
        else if (v < -(A_W+1)'(OUT_ONE))
            return -OUT_W'(OUT_ONE);
        else
            return OUT_W'(v);
    endfunction

    // two-factor products
    always_comb
    begin
        m1_next.ca_sb = P_W'(ca) * P_W'(sb);
        m1_next.sa_sb = P_W'(sa) * P_W'(sb);
        m1_next.ca_cb = P_W'(ca) * P_W'(cb);
        m1_next.sa_cb = P_W'(sa) * P_W'(cb);
        m1_next.sa_cg = P_W'(sa) * P_W'(cg);
        m1_next.sa_sg = P_W'(sa) * P_W'(sg);
        m1_next.ca_cg = P_W'(ca) * P_W'(cg);
        m1_next.ca_sg = P_W'(ca) * P_W'(sg);
        m1_next.cb_sg = P_W'(cb) * P_W'(sg);
        m1_next.cb_cg = P_W'(cb) * P_W'(cg);
        m1_next.sg = sg;
        m1_next.cg = cg;
        m1_next.sb = sb;
    end

    // round the first factor pair of the three-factor terms
    always_comb
    begin
        m2_next.t1 = round_fb(m1_reg.ca_sb);
        m2_next.t2 = round_fb(m1_reg.sa_sb);
        m2_next.ca_cb = m1_reg.ca_cb;
        m2_next.sa_cb = m1_reg.sa_cb;
        m2_next.sa_cg = m1_reg.sa_cg;
        m2_next.sa_sg = m1_reg.sa_sg;
        m2_next.ca_cg = m1_reg.ca_cg;
        m2_next.ca_sg = m1_reg.ca_sg;
        m2_next.cb_sg = m1_reg.cb_sg;
        m2_next.cb_cg = m1_reg.cb_cg;
        m2_next.sg = m1_reg.sg;
        m2_next.cg = m1_reg.cg;
        m2_next.sb = m1_reg.sb;
    end

    always_comb
    begin
        m3_next.t1_sg = Q_W'(m2_reg.t1) * Q_W'(m2_reg.sg);
        m3_next.t1_cg = Q_W'(m2_reg.t1) * Q_W'(m2_reg.cg);
        m3_next.t2_sg = Q_W'(m2_reg.t2) * Q_W'(m2_reg.sg);
        m3_next.t2_cg = Q_W'(m2_reg.t2) * Q_W'(m2_reg.cg);
        m3_next.ca_cb = m2_reg.ca_cb;
        m3_next.sa_cb = m2_reg.sa_cb;
        m3_next.sa_cg = m2_reg.sa_cg;
        m3_next.sa_sg = m2_reg.sa_sg;
        m3_next.ca_cg = m2_reg.ca_cg;
        m3_next.ca_sg = m2_reg.ca_sg;
        m3_next.cb_sg = m2_reg.cb_sg;
        m3_next.cb_cg = m2_reg.cb_cg;
        m3_next.sb = m2_reg.sb;
    end

    // exact sums with 2*fb fraction bits
    always_comb
    begin
        m4_next.a00 = A_W'(m3_reg.ca_cb);
        m4_next.a01 = A_W'(m3_reg.t1_sg) - A_W'(m3_reg.sa_cg);
        m4_next.a02 = A_W'(m3_reg.t1_cg) + A_W'(m3_reg.sa_sg);
        m4_next.a10 = A_W'(m3_reg.sa_cb);
        m4_next.a11 = A_W'(m3_reg.t2_sg) + A_W'(m3_reg.ca_cg);
        m4_next.a12 = A_W'(m3_reg.t2_cg) - A_W'(m3_reg.ca_sg);
        m4_next.a20 = -(A_W'(m3_reg.sb) <<< FRACTION_BITS);
        m4_next.a21 = A_W'(m3_reg.cb_sg);
        m4_next.a22 = A_W'(m3_reg.cb_cg);
    end

    always_comb
    begin
        mat_next.r00 = to_out(m4_reg.a00);
        mat_next.r01 = to_out(m4_reg.a01);
        mat_next.r02 = to_out(m4_reg.a02);
        mat_next.r10 = to_out(m4_reg.a10);
        mat_next.r11 = to_out(m4_reg.a11);
        mat_next.r12 = to_out(m4_reg.a12);
        mat_next.r20 = to_out(m4_reg.a20);
        mat_next.r21 = to_out(m4_reg.a21);
        mat_next.r22 = to_out(m4_reg.a22);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m1_reg  <= m1_next;
            m2_reg  <= m2_next;
            m3_reg  <= m3_next;
            m4_reg  <= m4_next;
            mat_reg <= mat_next;
        end
    end

    assign mat = mat_reg;

endmodule

### hw/rtl/rpy_to_rotation_matrix.sv
`timescale 1ns / 1ps
// throughput: one pose per cycle unless stalled, one cordic iteration per stage
// the whole pipeline advances together and holds while a result beat is not taken
// reset: asynchronous active-low rst_n clears the valid bits; data registers are not reset

module rpy_to_rotation_matrix
    import rpy_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    rpy_angle_if.sink    angles,
    rpy_matrix_if.source matrix
);

    // fold + iterations + undo-fold stage, then five matrix stages
    localparam int LAT = CORDIC_ITERATIONS + 7;

    logic [LAT-1:0] valid_reg;
    logic [LAT-1:0] valid_next;
    logic           en;

    logic signed [SC_W-1:0] sg, cg, sb, cb, sa, ca;
    matrix_t mat;

    // advance whenever the output slot is empty or being taken
    assign en = matrix.ready || !valid_reg[LAT-1];
    assign angles.ready = en;

    assign valid_next = {valid_reg[LAT-2:0], angles.valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= valid_next;
        end
    end

    // one sine/cosine lane per angle
    rpy_sincos u_roll (
        .clk     (clk),
        .en      (en),
        .angle   (angles.roll_angle),
        .sin_val (sg),
        .cos_val (cg)
    );

    rpy_sincos u_pitch (
        .clk     (clk),
        .en      (en),
        .angle   (angles.pitch_angle),
        .sin_val (sb),
        .cos_val (cb)
    );

    rpy_sincos u_yaw (
        .clk     (clk),
        .en      (en),
        .angle   (angles.yaw_angle),
        .sin_val (sa),
        .cos_val (ca)
    );

    // products, rounding, sums and saturation
    rpy_matrix u_matrix (
        .clk (clk),
        .en  (en),
        .sg  (sg),
        .cg  (cg),
        .sb  (sb),
        .cb  (cb),
        .sa  (sa),
        .ca  (ca),
        .mat (mat)
    );

    assign matrix.valid = valid_reg[LAT-1];
    assign matrix.r00   = mat.r00;
    assign matrix.r01   = mat.r01;
    assign matrix.r02   = mat.r02;
    assign matrix.r10   = mat.r10;
    assign matrix.r11   = mat.r11;
    assign matrix.r12   = mat.r12;
    assign matrix.r20   = mat.r20;
    assign matrix.r21   = mat.r21;
    assign matrix.r22   = mat.r22;

endmodule

### hw/rtl/rpy_checker.sv
`timescale 1ns / 1ps

module rpy_checker
    import rpy_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_ready,
    input logic                    out_valid,
    input logic                    out_ready,
    input logic signed [OUT_W-1:0] r00,
    input logic signed [OUT_W-1:0] r20
);

    // input held back only while a result beat is stuck
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
        else $error("input stalled without output back-pressure");

    // stuck result beat stays
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result beat dropped");

    // outputs r00 and r20 saturated to +-1
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (r00 <= OUT_W'(OUT_ONE) && r00 >= -OUT_W'(OUT_ONE)
                       && r20 <= OUT_W'(OUT_ONE) && r20 >= -OUT_W'(OUT_ONE)))
        else $error("matrix entry beyond unity");

    // empty pipeline right after reset
    a_reset: assert property (@(posedge clk) $rose(rst_n) |-> !out_valid)
        else $error("result beat right after reset");

endmodule

bind rpy_to_rotation_matrix rpy_checker u_rpy_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (angles.ready),
    .out_valid (matrix.valid),
    .out_ready (matrix.ready),
    .r00       (matrix.r00),
    .r20       (matrix.r20)
);
